[src/dts_pkg.sv]
// ----------------------------------------------------------------------------
// dts_pkg
// Shared types, sizes and codes for the delimiter token splitter.
// ----------------------------------------------------------------------------
package dts_pkg;

	// Longest delimiter and width of the token counters
	localparam int MAX_DELIM  = 8;
	localparam int COUNT_BITS = 16;

	// Register and field widths
	localparam int LEN_W   = 4;
	localparam int DELIM_W = 64;
	localparam int MAXT_W  = 16;
	localparam int CFG_W   = 64;
	localparam int IDX_W   = 2;

	// Window fill count, 0..MAX_DELIM
	localparam int FILL_W = $clog2(MAX_DELIM + 1);
	localparam int BIDX_W = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;

	// Result slots of one item: head byte, delimiter marker, tail bytes, line end
	localparam int SLOT_HEAD = 0;
	localparam int SLOT_MARK = 1;
	localparam int SLOT_TAIL = 2;
	localparam int SLOT_END  = MAX_DELIM + 2;
	localparam int NSLOT     = MAX_DELIM + 3;
	localparam int SLOT_W    = $clog2(NSLOT);

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_DELIM_LENGTH = 2'd0,
		REG_DELIM_BYTES  = 2'd1,
		REG_MAX_TOKENS   = 2'd2
	} cfg_reg_t;

	// All results caused by one item, in compact form
	typedef struct packed {
		logic [NSLOT-1:0]            slots;
		logic [7:0]                  hd_byte;
		logic [COUNT_BITS-1:0]       hd_num;
		logic [COUNT_BITS-1:0]       mk_num;
		logic [COUNT_BITS-1:0]       mk_cnt;
		logic                        tl_mk;
		logic [FILL_W-1:0]           tl_n;
		logic [MAX_DELIM-1:0][7:0]   tl_bytes;
		logic [COUNT_BITS-1:0]       tl_num;
		logic [COUNT_BITS-1:0]       tl_cnt;
		logic [COUNT_BITS-1:0]       se_cnt;
	} bundle_t;

	// Hand-off from the step logic to the result queue
	typedef struct packed {
		logic    valid;
		bundle_t item;
	} push_t;

endpackage

[src/dts_byte_if.sv]
// ----------------------------------------------------------------------------
// dts_byte_if
// Input byte channel: valid/ready with one byte and its end-of-line flag.
// ----------------------------------------------------------------------------
interface dts_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

[src/dts_result_if.sv]
// ----------------------------------------------------------------------------
// dts_result_if
// Result channel: valid/ready with token byte, markers and counts.
// ----------------------------------------------------------------------------
interface dts_result_if;
	logic                          valid;
	logic                          ready;
	logic [7:0]                    token_byte;
	logic                          byte_valid;
	logic                          token_end;
	logic [dts_pkg::COUNT_BITS-1:0] token_number;
	logic                          stream_end;
	logic [dts_pkg::COUNT_BITS-1:0] token_count;

	modport source (output valid, output token_byte, output byte_valid, output token_end,
		output token_number, output stream_end, output token_count, input ready);
	modport sink (input valid, input token_byte, input byte_valid, input token_end,
		input token_number, input stream_end, input token_count, output ready);
endinterface

[src/dts_step.sv]
// ----------------------------------------------------------------------------
// dts_step
// Configuration registers, match window and line state. Works out all
// results of an accepted byte in one pass and hands them on as one bundle.
// ----------------------------------------------------------------------------
module dts_step (
	input  logic                        clk,
	input  logic                        arst_n,
	dts_byte_if.sink                    stream,
	input  logic                        room,
	input  logic                        cfg_wr_en,
	input  logic [dts_pkg::IDX_W-1:0]   cfg_index,
	input  logic [dts_pkg::CFG_W-1:0]   cfg_data,
	output dts_pkg::push_t              push
);

	localparam int MD = dts_pkg::MAX_DELIM;
	localparam int FW = dts_pkg::FILL_W;
	localparam int CW = dts_pkg::COUNT_BITS;

	// Configuration
	logic [dts_pkg::LEN_W-1:0]   len_q;
	logic [dts_pkg::DELIM_W-1:0] delim_q;
	logic [dts_pkg::MAXT_W-1:0]  maxt_q;

	// Line state
	logic [7:0]    win_q [MD];
	logic [FW-1:0] fill_q;
	logic          open_q;
	logic [CW-1:0] td_q;
	logic          lim_q;

	// Next state
	logic [7:0]    w [MD];
	logic [FW-1:0] f;
	logic          open;
	logic [CW-1:0] td;
	logic          lim;
	logic          match;
	dts_pkg::bundle_t bnd;

	logic [FW-1:0] len_eff;
	logic [CW-1:0] td_fin;
	logic          lim_fin;
	logic          accept;
	logic          len_wr;
	logic [MD*8+dts_pkg::DELIM_W-1:0] dpad;

	assign stream.ready = room;
	assign accept       = stream.valid && room;
	assign len_wr       = cfg_wr_en && (cfg_index == dts_pkg::REG_DELIM_LENGTH);
	assign dpad         = {{(MD*8){1'b0}}, delim_q};

	// Effective delimiter length, clamped to 1..MAX_DELIM
	always_comb begin
		if (len_q == '0) begin
			len_eff = FW'(1);
		end else if (32'(len_q) > MD) begin
			len_eff = FW'(MD);
		end else begin
			len_eff = FW'(len_q);
		end
	end

	// Token count after closing the open token, and the limit check on it
	assign td_fin  = (td_q == '1) ? td_q : td_q + CW'(1);
	assign lim_fin = (maxt_q != '0) && (32'(td_fin) >= 32'(maxt_q));

	// One pass over the item: head byte, append, match, line end
	always_comb begin
		w     = win_q;
		f     = fill_q;
		open  = open_q;
		td    = td_q;
		lim   = lim_q;
		match = 1'b0;
		bnd   = '0;
		if (!lim_q) begin
			if (f >= len_eff) begin
				open              = 1'b1;
				bnd.slots[dts_pkg::SLOT_HEAD] = 1'b1;
				bnd.hd_byte       = w[0];
				bnd.hd_num        = td_q;
				for (int i = 0; i < MD - 1; i++) begin
					w[i] = w[i+1];
				end
				f = f - FW'(1);
			end
			for (int i = 0; i < MD; i++) begin
				if (FW'(i) == f) begin
					w[i] = stream.data_byte;
				end
			end
			f     = f + FW'(1);
			match = (f == len_eff);
			for (int i = 0; i < MD; i++) begin
				if (FW'(i) < len_eff && w[i] != dpad[8*i +: 8]) begin
					match = 1'b0;
				end
			end
			if (match) begin
				f = '0;
				if (open) begin
					bnd.slots[dts_pkg::SLOT_MARK] = 1'b1;
					bnd.mk_num = td_q;
					bnd.mk_cnt = td_fin;
					td         = td_fin;
					open       = 1'b0;
					if (lim_fin) begin
						lim = 1'b1;
					end
				end
			end
		end
		if (stream.last_byte) begin
			if (!lim) begin
				if (f != '0) begin
					bnd.tl_n   = f;
					bnd.tl_num = td_q;
					bnd.tl_cnt = td_fin;
					for (int i = 0; i < MD; i++) begin
						bnd.tl_bytes[i] = w[i];
						if (FW'(i) < f) begin
							bnd.slots[dts_pkg::SLOT_TAIL + i] = 1'b1;
						end
					end
					td = td_fin;
				end else if (open) begin
					bnd.tl_mk  = 1'b1;
					bnd.tl_num = td_q;
					bnd.tl_cnt = td_fin;
					bnd.slots[dts_pkg::SLOT_TAIL] = 1'b1;
					td = td_fin;
				end
			end
			bnd.slots[dts_pkg::SLOT_END] = 1'b1;
			bnd.se_cnt = td;
			f    = '0;
			open = 1'b0;
			td   = '0;
			lim  = 1'b0;
		end else if (lim) begin
			f = '0;
		end
	end

	assign push.valid = accept && (bnd.slots != '0);
	assign push.item  = bnd;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= dts_pkg::LEN_W'(1);
			delim_q <= dts_pkg::DELIM_W'(32);
			maxt_q  <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				dts_pkg::REG_DELIM_LENGTH: len_q   <= cfg_data[dts_pkg::LEN_W-1:0];
				dts_pkg::REG_DELIM_BYTES:  delim_q <= cfg_data[dts_pkg::DELIM_W-1:0];
				dts_pkg::REG_MAX_TOKENS:   maxt_q  <= cfg_data[dts_pkg::MAXT_W-1:0];
				default: ;
			endcase
		end
	end

	// Line state; a length write starts a new line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			open_q <= 1'b0;
			td_q   <= '0;
			lim_q  <= 1'b0;
		end else if (len_wr) begin
			fill_q <= '0;
			open_q <= 1'b0;
			td_q   <= '0;
			lim_q  <= 1'b0;
		end else if (accept) begin
			fill_q <= f;
			open_q <= open;
			td_q   <= td;
			lim_q  <= lim;
		end
	end

	// Window bytes
	always_ff @(posedge clk) begin
		if (accept) begin
			win_q <= w;
		end
	end

endmodule

[src/dts_emit.sv]
// ----------------------------------------------------------------------------
// dts_emit
// Two-entry queue of result bundles; sends the results of the head bundle
// one per cycle while result ready is high, lowest slot first.
// ----------------------------------------------------------------------------
module dts_emit (
	input  logic           clk,
	input  logic           arst_n,
	input  dts_pkg::push_t push,
	output logic           room,
	dts_result_if.source   result
);

	localparam int NS = dts_pkg::NSLOT;
	localparam int SW = dts_pkg::SLOT_W;

	dts_pkg::bundle_t ent_q [2];
	logic       rd_ptr_q;
	logic       wr_ptr_q;
	logic [1:0] level_q;

	dts_pkg::bundle_t head;
	logic [NS-1:0] mask;
	logic [NS-1:0] low;
	logic          last_one;
	logic [SW-1:0] slot;
	logic [SW-1:0] ti;
	logic          take;
	logic          pop;

	assign room     = (level_q != 2'd2);
	assign head     = ent_q[rd_ptr_q];
	assign mask     = head.slots;
	assign low      = mask & (~mask + NS'(1));
	assign last_one = (mask == low);
	assign take     = result.valid && result.ready;
	assign pop      = take && last_one;

	// Slot number of the lowest pending result
	always_comb begin
		slot = '0;
		for (int i = 0; i < NS; i++) begin
			if (low[i]) begin
				slot = SW'(i);
			end
		end
	end

	assign ti = slot - SW'(dts_pkg::SLOT_TAIL);

	// Result fields for the chosen slot
	always_comb begin
		result.valid        = (level_q != 2'd0);
		result.token_byte   = '0;
		result.byte_valid   = 1'b0;
		result.token_end    = 1'b0;
		result.token_number = '0;
		result.stream_end   = 1'b0;
		result.token_count  = '0;
		if (slot == SW'(dts_pkg::SLOT_HEAD)) begin
			result.token_byte   = head.hd_byte;
			result.byte_valid   = 1'b1;
			result.token_number = head.hd_num;
			result.token_count  = head.hd_num;
		end else if (slot == SW'(dts_pkg::SLOT_MARK)) begin
			result.token_end    = 1'b1;
			result.token_number = head.mk_num;
			result.token_count  = head.mk_cnt;
		end else if (slot == SW'(dts_pkg::SLOT_END)) begin
			result.stream_end   = 1'b1;
			result.token_count  = head.se_cnt;
		end else if (head.tl_mk) begin
			result.token_end    = 1'b1;
			result.token_number = head.tl_num;
			result.token_count  = head.tl_cnt;
		end else begin
			result.token_byte   = head.tl_bytes[ti[dts_pkg::BIDX_W-1:0]];
			result.byte_valid   = 1'b1;
			result.token_number = head.tl_num;
			result.token_end    = (32'(ti) + 1 == 32'(head.tl_n));
			result.token_count  = result.token_end ? head.tl_cnt : head.tl_num;
		end
	end

	// Queue pointers and level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			level_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			level_q <= level_q + {1'b0, push.valid} - {1'b0, pop};
		end
	end

	// Bundle storage; the head retires one slot per result taken
	always_ff @(posedge clk) begin
		if (push.valid) begin
			ent_q[wr_ptr_q] <= push.item;
		end
		if (take && !last_one) begin
			ent_q[rd_ptr_q].slots <= mask & ~low;
		end
	end

endmodule

[src/delimiter_token_splitter_unit.sv]
// ----------------------------------------------------------------------------
// delimiter_token_splitter_unit
// Splits a byte stream into tokens at a configured 1 to 8 byte delimiter.
// ----------------------------------------------------------------------------
// The unit takes one byte per clock while the result queue has room. Each
// accepted byte is matched against the delimiter combinationally and all of
// its results are queued as one bundle in a two-entry queue, which registers
// the bundle; the result channel then sends them one per cycle while the
// receiver is ready. A byte yields at most one result, except a byte that
// closes a token on a delimiter (two results) and the last byte of a line
// (up to delimiter length plus two results); such bytes can fill the queue
// and hold the input, as the single result port sends one result at a time.
// Token bytes lag the input by the delimiter length. No clearing pass is
// needed after reset. The user must write configuration only while the unit
// is idle; the unit does not enforce it. Writing the length starts a new line.
// ----------------------------------------------------------------------------
module delimiter_token_splitter_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	dts_byte_if.sink                  stream,
	dts_result_if.source              result,
	input  logic                      cfg_wr_en,
	input  logic [dts_pkg::IDX_W-1:0] cfg_index,
	input  logic [dts_pkg::CFG_W-1:0] cfg_data
);

	dts_pkg::push_t push;
	logic           room;

	// Matching and line state
	dts_step u_step (
		.clk       (clk),
		.arst_n    (arst_n),
		.stream    (stream),
		.room      (room),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push)
	);

	// Result queue and serializer
	dts_emit u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.result (result)
	);

	// Queue only fills up through an accepted item
	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(stream.ready) |-> $past(stream.valid && stream.ready))
		else $error("input ready dropped without an accepted item");

	// A closing marker counts exactly one more token (or stays saturated)
	a_end_count: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.token_end |->
			(result.token_count == result.token_number + 16'd1) ||
			(result.token_number == '1 && result.token_count == '1))
		else $error("token_end count mismatch");

	// Line end result carries no byte, no marker and token number zero
	a_stream_end: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.stream_end |->
			!result.byte_valid && !result.token_end && result.token_number == '0)
		else $error("malformed stream end result");

	// Results without a token byte carry a zero byte
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.byte_valid |-> result.token_byte == 8'd0)
		else $error("token byte set without byte_valid");

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the delimiter token splitter. A directed table
// covers the field extremes, empty tokens, partial delimiters, length
// clamping, the token limit and mid-line register writes. Random lines
// follow under four handshake-pressure phases. Every result is checked
// field by field against the splitter model or a typed row's own result.
// ----------------------------------------------------------------------------
module tb;

	localparam int SETTLE_CYCLES = 16;      // covers the result queue and pipe
	localparam int ITEMS_PER_PHASE = 16;

	typedef struct packed {
		logic [7:0]                     token_byte;
		logic                           byte_valid;
		logic                           token_end;
		logic [dts_pkg::COUNT_BITS-1:0] token_number;
		logic                           stream_end;
		logic [dts_pkg::COUNT_BITS-1:0] token_count;
	} tok_res_t;

	typedef enum logic [1:0] {
		ROW_WRITE,
		ROW_BYTE
	} row_kind_t;

	typedef struct {
		row_kind_t                 kind;
		dts_pkg::cfg_reg_t         sel;
		logic [dts_pkg::CFG_W-1:0] wr_data;
		logic [7:0]                b;
		logic                      last;
		bit                        typed;
		tok_res_t                  want;
	} stim_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_wr_en;
	dts_pkg::cfg_reg_t         cfg_index;
	logic [dts_pkg::CFG_W-1:0] cfg_data;

	dts_byte_if   stream_if ();
	dts_result_if result_if ();

	delimiter_token_splitter_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.stream    (stream_if),
		.result    (result_if),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Splitter model: registers and line state
	logic [dts_pkg::LEN_W-1:0]      len_reg;
	logic [dts_pkg::DELIM_W-1:0]    delim_reg;
	logic [dts_pkg::MAXT_W-1:0]     max_reg;
	logic [7:0]                     win_buf [dts_pkg::MAX_DELIM];
	int                             win_fill;
	bit                             tok_open;
	bit                             lim_hit;
	logic [dts_pkg::COUNT_BITS-1:0] done_cnt;

	tok_res_t  step_res[$];     // results of the byte just split
	tok_res_t  pending_res[$];  // results still owed by the unit
	stim_row_t dir_rows[$];

	int send_idle_pct;
	int recv_stall_pct;
	int err_cnt;
	int res_idx;
	int fed_cnt;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Give up well past the slowest legal run
	initial begin
		#(20_000_000);
		$display("Verification failed");
		$finish;
	end

	function automatic tok_res_t mk_res(input logic [7:0] tb_byte, input logic bv,
			input logic te, input logic [dts_pkg::COUNT_BITS-1:0] num, input logic se,
			input logic [dts_pkg::COUNT_BITS-1:0] cnt);
		tok_res_t r;
		r.token_byte   = tb_byte;
		r.byte_valid   = bv;
		r.token_end    = te;
		r.token_number = num;
		r.stream_end   = se;
		r.token_count  = cnt;
		return r;
	endfunction

	function automatic int eff_len();
		int l;
		l = int'(len_reg);
		if (l < 1) l = 1;
		if (l > dts_pkg::MAX_DELIM) l = dts_pkg::MAX_DELIM;
		return l;
	endfunction

	function automatic void clear_line();
		win_fill = 0;
		tok_open = 1'b0;
		done_cnt = '0;
		lim_hit  = 1'b0;
	endfunction

	// Count the open token, saturating, and check the limit
	function automatic void close_token();
		if (done_cnt != '1) done_cnt++;
		tok_open = 1'b0;
		if (max_reg != '0 && done_cnt >= max_reg) begin
			lim_hit  = 1'b1;
			win_fill = 0;
		end
	endfunction

	// Split one byte; fills step_res with the results it causes
	function automatic void split_byte(input logic [7:0] b, input logic last);
		int l;
		int i;
		int f;
		bit hit;
		logic [dts_pkg::COUNT_BITS-1:0] num;
		l = eff_len();
		step_res.delete();
		if (!lim_hit) begin
			// oldest held byte leaves a full window as a token byte
			if (win_fill >= l) begin
				tok_open = 1'b1;
				step_res = {step_res,
					mk_res(win_buf[0], 1'b1, 1'b0, done_cnt, 1'b0, done_cnt)};
				for (i = 1; i < win_fill; i++) win_buf[i-1] = win_buf[i];
				win_fill--;
			end
			if (win_fill < dts_pkg::MAX_DELIM) begin
				win_buf[win_fill] = b;
				win_fill++;
			end
			// full window equal to the delimiter is dropped
			if (win_fill == l) begin
				hit = 1'b1;
				for (i = 0; i < l; i++)
					if (win_buf[i] != delim_reg[8*i +: 8]) hit = 1'b0;
				if (hit) begin
					win_fill = 0;
					if (tok_open) begin
						num = done_cnt;
						close_token();
						step_res = {step_res,
							mk_res(8'h00, 1'b0, 1'b1, num, 1'b0, done_cnt)};
					end
				end
			end
		end
		// line end: flush held bytes, close the token, report the count
		if (last) begin
			if (!lim_hit) begin
				if (win_fill > 0) begin
					f = win_fill;
					num = done_cnt;
					tok_open = 1'b1;
					for (i = 0; i + 1 < f; i++)
						step_res = {step_res,
							mk_res(win_buf[i], 1'b1, 1'b0, num, 1'b0, num)};
					close_token();
					step_res = {step_res,
						mk_res(win_buf[f-1], 1'b1, 1'b1, num, 1'b0, done_cnt)};
				end else if (tok_open) begin
					num = done_cnt;
					close_token();
					step_res = {step_res,
						mk_res(8'h00, 1'b0, 1'b1, num, 1'b0, done_cnt)};
				end
			end
			step_res = {step_res, mk_res(8'h00, 1'b0, 1'b0, '0, 1'b1, done_cnt)};
			clear_line();
		end
	endfunction

	task automatic report_mismatch(input string msg);
		err_cnt++;
		$display("[%0t] %s", $time, msg);
	endtask

	task automatic cmp_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s: expected %0h got %0h",
				res_idx, name, want, got));
	endtask

	task automatic check_result();
		tok_res_t want;
		if (pending_res.size() == 0) begin
			report_mismatch($sformatf("result %0d with nothing pending: byte %02h end %0b se %0b",
				res_idx, result_if.token_byte, result_if.token_end, result_if.stream_end));
		end else begin
			want = pending_res.pop_front();
			cmp_field("token_byte", 16'(want.token_byte), 16'(result_if.token_byte));
			cmp_field("byte_valid", 16'(want.byte_valid), 16'(result_if.byte_valid));
			cmp_field("token_end", 16'(want.token_end), 16'(result_if.token_end));
			cmp_field("token_number", want.token_number, result_if.token_number);
			cmp_field("stream_end", 16'(want.stream_end), 16'(result_if.stream_end));
			cmp_field("token_count", want.token_count, result_if.token_count);
		end
		res_idx++;
	endtask

	// Result side: random stall, sampled at the rising edge
	initial result_if.ready = 1'b0;

	always @(negedge clk) begin
		result_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) check_result();
	end

	task automatic write_reg(input dts_pkg::cfg_reg_t sel,
			input logic [dts_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		@(posedge clk);
		case (sel)
			dts_pkg::REG_DELIM_LENGTH: begin
				len_reg = val[dts_pkg::LEN_W-1:0];
				clear_line();
			end
			dts_pkg::REG_DELIM_BYTES:  delim_reg = val[dts_pkg::DELIM_W-1:0];
			dts_pkg::REG_MAX_TOKENS:   max_reg = val[dts_pkg::MAXT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Hold the stream until every owed result is out, then let the pipe settle
	task automatic drain_results();
		@(negedge clk);
		stream_if.valid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Offer one byte; a typed row replaces the model's results with its own
	task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
			input tok_res_t want);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			stream_if.valid <= 1'b0;
			@(negedge clk);
		end
		stream_if.valid     <= 1'b1;
		stream_if.data_byte <= b;
		stream_if.last_byte <= last;
		do @(posedge clk); while (!stream_if.ready);
		fed_cnt++;
		split_byte(b, last);
		if (typed) pending_res = {pending_res, want};
		else pending_res = {pending_res, step_res};
	endtask

	// Random line: runs of 0..3 bytes, each followed by a full, partial or no delimiter
	task automatic send_random_line();
		logic [7:0] line_q[$];
		int l;
		int nb;
		int pick;
		int plen;
		int j;
		l = eff_len();
		repeat ($urandom_range(1, 4)) begin
			nb = $urandom_range(0, 3);
			repeat (nb) line_q = {line_q, 8'($urandom_range(0, 255))};
			pick = $urandom_range(0, 9);
			if (pick <= 6) plen = l;
			else if (pick == 7 && l > 1) plen = $urandom_range(1, l - 1);
			else plen = 0;
			for (j = 0; j < plen; j++) line_q = {line_q, delim_reg[8*j +: 8]};
		end
		if (line_q.size() == 0) line_q = {line_q, 8'($urandom_range(0, 255))};
		foreach (line_q[k]) begin
			// now and then let the unit run dry mid-line
			if ($urandom_range(0, 29) == 0) drain_results();
			send_byte(line_q[k], k == line_q.size() - 1, 1'b0, '0);
		end
	endtask

	function automatic void row_wr(input dts_pkg::cfg_reg_t sel,
			input logic [dts_pkg::CFG_W-1:0] val);
		stim_row_t r;
		r = '{kind: ROW_WRITE, sel: sel, wr_data: val, b: 8'h00, last: 1'b0,
			typed: 1'b0, want: '0};
		dir_rows = {dir_rows, r};
	endfunction

	function automatic void row_byte(input logic [7:0] b, input logic last);
		stim_row_t r;
		r = '{kind: ROW_BYTE, sel: dts_pkg::REG_DELIM_LENGTH, wr_data: '0, b: b,
			last: last, typed: 1'b0, want: '0};
		dir_rows = {dir_rows, r};
	endfunction

	// Last byte whose only result is the line end with the given count
	function automatic void row_line_end(input logic [7:0] b,
			input logic [dts_pkg::COUNT_BITS-1:0] cnt);
		stim_row_t r;
		r = '{kind: ROW_BYTE, sel: dts_pkg::REG_DELIM_LENGTH, wr_data: '0, b: b,
			last: 1'b1, typed: 1'b1, want: mk_res(8'h00, 1'b0, 1'b0, '0, 1'b1, cnt)};
		dir_rows = {dir_rows, r};
	endfunction

	initial begin
		int ph;
		int target;
		int wait_cnt;
		logic [dts_pkg::LEN_W-1:0] ph_len;
		logic [dts_pkg::MAXT_W-1:0] ph_max;

		arst_n              = 1'b0;
		cfg_wr_en           = 1'b0;
		cfg_index           = dts_pkg::REG_DELIM_LENGTH;
		cfg_data            = '0;
		stream_if.valid     = 1'b0;
		stream_if.data_byte = 8'h00;
		stream_if.last_byte = 1'b0;
		send_idle_pct       = 0;
		recv_stall_pct      = 0;
		err_cnt             = 0;
		res_idx             = 0;
		fed_cnt             = 0;
		len_reg             = dts_pkg::LEN_W'(1);
		delim_reg           = dts_pkg::DELIM_W'(32);
		max_reg             = '0;
		clear_line();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset defaults: a lone space is an empty token, nothing but the line end
		row_line_end(8'h20, 16'd0);
		// byte extremes, no delimiter in the line
		row_byte(8'h00, 1'b0);
		row_byte(8'hFF, 1'b1);
		// two-byte delimiter: leading and back-to-back delimiters, partial at the end
		row_wr(dts_pkg::REG_DELIM_BYTES, 64'h7978);
		row_wr(dts_pkg::REG_DELIM_LENGTH, 64'd2);
		row_byte(8'h78, 1'b0);
		row_byte(8'h79, 1'b0);
		row_byte(8'h71, 1'b0);
		row_byte(8'h78, 1'b0);
		row_byte(8'h79, 1'b0);
		row_byte(8'h78, 1'b0);
		row_byte(8'h79, 1'b0);
		row_byte(8'h72, 1'b0);
		row_byte(8'h78, 1'b1);
		// length zero acts as one; zero byte as the delimiter
		row_wr(dts_pkg::REG_DELIM_LENGTH, 64'd0);
		row_wr(dts_pkg::REG_DELIM_BYTES, 64'h0);
		row_byte(8'h41, 1'b0);
		row_byte(8'h00, 1'b1);
		// length above the maximum clamps, all-ones delimiter
		row_wr(dts_pkg::REG_DELIM_LENGTH, 64'd15);
		row_wr(dts_pkg::REG_DELIM_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
		row_byte(8'h5A, 1'b0);
		row_byte(8'hAA, 1'b1);
		// limit of one token: later bytes are dropped
		row_wr(dts_pkg::REG_DELIM_LENGTH, 64'd1);
		row_wr(dts_pkg::REG_DELIM_BYTES, 64'h2C);
		row_wr(dts_pkg::REG_MAX_TOKENS, 64'd1);
		row_byte(8'h61, 1'b0);
		row_byte(8'h2C, 1'b0);
		row_byte(8'h62, 1'b0);
		row_line_end(8'h63, 16'd1);
		// length write in the middle of a line restarts it
		row_wr(dts_pkg::REG_MAX_TOKENS, 64'd0);
		row_byte(8'h61, 1'b0);
		row_byte(8'h62, 1'b0);
		row_wr(dts_pkg::REG_DELIM_LENGTH, 64'd1);
		row_byte(8'h63, 1'b1);
		// limit lowered to the count mid-line takes hold at the next token
		row_byte(8'h61, 1'b0);
		row_byte(8'h2C, 1'b0);
		row_wr(dts_pkg::REG_MAX_TOKENS, 64'd1);
		row_byte(8'h62, 1'b0);
		row_byte(8'h2C, 1'b0);
		row_line_end(8'h63, 16'd2);

		foreach (dir_rows[k]) begin
			if (dir_rows[k].kind == ROW_WRITE) begin
				drain_results();
				write_reg(dir_rows[k].sel, dir_rows[k].wr_data);
			end else begin
				send_byte(dir_rows[k].b, dir_rows[k].last, dir_rows[k].typed, dir_rows[k].want);
			end
		end

		// Random lines under each handshake phase
		for (ph = 0; ph < 4; ph++) begin
			drain_results();
			case (ph)
				0: begin
					send_idle_pct = 0;  recv_stall_pct = 0;
					ph_len = dts_pkg::LEN_W'(8); ph_max = '0;
				end
				1: begin
					send_idle_pct = 64; recv_stall_pct = 0;
					ph_len = dts_pkg::LEN_W'(1); ph_max = '1;
				end
				2: begin
					send_idle_pct = 0;  recv_stall_pct = 64;
					ph_len = dts_pkg::LEN_W'($urandom_range(2, 7));
					ph_max = dts_pkg::MAXT_W'(2);
				end
				default: begin
					send_idle_pct = 12; recv_stall_pct = 12;
					ph_len = dts_pkg::LEN_W'(4); ph_max = dts_pkg::MAXT_W'(3);
				end
			endcase
			write_reg(dts_pkg::REG_DELIM_LENGTH, dts_pkg::CFG_W'(ph_len));
			write_reg(dts_pkg::REG_DELIM_BYTES, {$urandom(), $urandom()});
			write_reg(dts_pkg::REG_MAX_TOKENS, dts_pkg::CFG_W'(ph_max));
			target = fed_cnt + ITEMS_PER_PHASE;
			while (fed_cnt < target) send_random_line();
		end

		// Wind down: wait for the owed results, then watch for strays
		@(negedge clk);
		stream_if.valid <= 1'b0;
		wait_cnt = 0;
		while (pending_res.size() != 0 && wait_cnt < 100000) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		if (pending_res.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_res.size()));

		if (err_cnt == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
